### rtl/mpab_pkg.sv
// Types and constants of the multi-pattern automaton builder.
// No dependencies; imported by the top level of the block.
package mpab_pkg;

  // Widths of the fields on the command and result ports
  localparam int unsigned OP_FW    = 2;
  localparam int unsigned SYM_FW   = 5;
  localparam int unsigned NODE_FW  = 10;
  localparam int unsigned COUNT_FW = 11;

  // Operation codes
  typedef enum logic [OP_FW-1:0] {
    OP_INSERT = 2'd0,
    OP_END    = 2'd1,
    OP_BUILD  = 2'd2,
    OP_READ   = 2'd3
  } mpab_op_e;

  // Command word
  typedef struct packed {
    mpab_op_e            operation;
    logic [SYM_FW-1:0]   symbol;
    logic [NODE_FW-1:0]  query_node;
  } mpab_cmd_t;

  // Result word
  typedef struct packed {
    logic [NODE_FW-1:0]  next_node;
    logic [NODE_FW-1:0]  fail_node;
    logic                is_end;
    logic [COUNT_FW-1:0] node_count;
    logic                status;
  } mpab_res_t;

endpackage

### rtl/multi_pattern_automaton_builder_unit.sv
// Top level of the multi-pattern automaton builder (trie plus failure links).
// Depends on mpab_pkg and mpab_ram.
//
//   channel   ports                    direction  handshake
//   command   start, busy, cmd_i       in         taken when start & !busy
//   result    done_o, res_o            out        one-cycle strobe, no stall
//
// Insert reads the transition memory, then writes it when a new node is needed;
// read reads the transition, failure-link and end memories. End, an insert with
// an out-of-range letter and a read past the node table finish from idle. Build
// walks the root row letter by letter, then each queued node: each of its letters
// needs the failure link and two reads of the single-read-port transition memory.
// After reset a clearing pass zeroes the transition, failure-link and end
// memories; busy stays high meanwhile.
// The result strobe is registered; the receiver cannot stall it.
module multi_pattern_automaton_builder_unit #(
  parameter int unsigned MAX_NODES     = 1024,
  parameter int unsigned ALPHABET_SIZE = 26
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  mpab_pkg::mpab_cmd_t cmd_i,
  output logic               done_o,
  output mpab_pkg::mpab_res_t res_o
);
  import mpab_pkg::*;

  localparam int unsigned NODE_W = $clog2(MAX_NODES);
  localparam int unsigned SYM_W  = $clog2(ALPHABET_SIZE);
  localparam int unsigned ADDR_W = NODE_W + SYM_W;
  localparam int unsigned CNT_W  = $clog2(MAX_NODES + 1);

  typedef enum logic [10:0] {
    ST_CLEAR = 11'b000_0000_0001,
    ST_IDLE  = 11'b000_0000_0010,
    ST_INS   = 11'b000_0000_0100,
    ST_RD    = 11'b000_0000_1000,
    ST_R1    = 11'b000_0001_0000,
    ST_R2    = 11'b000_0010_0000,
    ST_BQ    = 11'b000_0100_0000,
    ST_BU    = 11'b000_1000_0000,
    ST_B1    = 11'b001_0000_0000,
    ST_B2    = 11'b010_0000_0000,
    ST_B3    = 11'b100_0000_0000
  } state_e;

  state_e            state_q, state_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  mpab_cmd_t         cmd_q, cmd_d;
  logic [NODE_W-1:0] cursor_q, cursor_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  head_q, head_d;
  logic [CNT_W-1:0]  tail_q, tail_d;
  logic [SYM_W-1:0]  let_q, let_d;
  logic [NODE_W-1:0] u_q, u_d;
  logic [NODE_W-1:0] nxt_q, nxt_d;
  mpab_res_t         res_q, res_d;
  logic              done_q, done_d;

  // memory ports
  logic              tr_we;
  logic [ADDR_W-1:0] tr_waddr, tr_raddr;
  logic [NODE_W-1:0] tr_wdata, tr_rdata;
  logic              fl_we;
  logic [NODE_W-1:0] fl_waddr, fl_raddr, fl_wdata, fl_rdata;
  logic              em_we, em_wdata, em_rdata;
  logic [NODE_W-1:0] em_waddr, em_raddr;
  logic              bq_we;
  logic [NODE_W-1:0] bq_waddr, bq_raddr, bq_wdata, bq_rdata;

  logic              let_last;
  logic              sym_ok_in, sym_ok_q, node_ok_in, node_ok_q;
  logic [SYM_W-1:0]  sym_in_idx, sym_q_idx;
  logic              room, tail_room;

  mpab_ram #(.DEPTH(2 ** ADDR_W), .WIDTH(NODE_W)) u_trans (
    .clk_i, .we_i(tr_we), .waddr_i(tr_waddr), .wdata_i(tr_wdata),
    .raddr_i(tr_raddr), .rdata_o(tr_rdata)
  );
  mpab_ram #(.DEPTH(MAX_NODES), .WIDTH(NODE_W)) u_fail (
    .clk_i, .we_i(fl_we), .waddr_i(fl_waddr), .wdata_i(fl_wdata),
    .raddr_i(fl_raddr), .rdata_o(fl_rdata)
  );
  mpab_ram #(.DEPTH(MAX_NODES), .WIDTH(1)) u_end (
    .clk_i, .we_i(em_we), .waddr_i(em_waddr), .wdata_i(em_wdata),
    .raddr_i(em_raddr), .rdata_o(em_rdata)
  );
  mpab_ram #(.DEPTH(MAX_NODES), .WIDTH(NODE_W)) u_queue (
    .clk_i, .we_i(bq_we), .waddr_i(bq_waddr), .wdata_i(bq_wdata),
    .raddr_i(bq_raddr), .rdata_o(bq_rdata)
  );

  // range checks on incoming and latched fields
  assign sym_ok_in  = int'(cmd_i.symbol) < ALPHABET_SIZE;
  assign sym_ok_q   = int'(cmd_q.symbol) < ALPHABET_SIZE;
  assign node_ok_in = int'(cmd_i.query_node) < MAX_NODES;
  assign node_ok_q  = int'(cmd_q.query_node) < MAX_NODES;
  assign sym_in_idx = SYM_W'(cmd_i.symbol);
  assign sym_q_idx  = SYM_W'(cmd_q.symbol);
  assign let_last   = let_q == SYM_W'(ALPHABET_SIZE - 1);
  assign room       = count_q < CNT_W'(MAX_NODES);
  assign tail_room  = tail_q < CNT_W'(MAX_NODES);

  // sequencer
  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    cmd_d    = cmd_q;
    cursor_d = cursor_q;
    count_d  = count_q;
    head_d   = head_q;
    tail_d   = tail_q;
    let_d    = let_q;
    u_d      = u_q;
    nxt_d    = nxt_q;
    res_d    = res_q;
    done_d   = 1'b0;
    tr_we    = 1'b0;
    tr_waddr = '0;
    tr_wdata = '0;
    tr_raddr = '0;
    fl_we    = 1'b0;
    fl_waddr = '0;
    fl_wdata = '0;
    fl_raddr = '0;
    em_we    = 1'b0;
    em_waddr = '0;
    em_wdata = 1'b0;
    em_raddr = '0;
    bq_we    = 1'b0;
    bq_waddr = '0;
    bq_wdata = '0;
    bq_raddr = '0;

    unique case (state_q)
      ST_CLEAR: begin
        tr_we    = 1'b1;
        tr_waddr = clr_q;
        fl_waddr = clr_q[NODE_W-1:0];
        em_waddr = clr_q[NODE_W-1:0];
        fl_we    = int'(clr_q[NODE_W-1:0]) < MAX_NODES;
        em_we    = fl_we;
        clr_d    = clr_q + 1'b1;
        if (&clr_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd_d = cmd_i;
          res_d = '0;
          unique case (cmd_i.operation)
            OP_INSERT: begin
              if (sym_ok_in) begin
                tr_raddr = {cursor_q, sym_in_idx};
                state_d  = ST_INS;
              end else begin
                res_d.next_node = NODE_FW'(cursor_q);
                done_d          = 1'b1;
              end
            end
            OP_END: begin
              em_we    = 1'b1;
              em_waddr = cursor_q;
              em_wdata = 1'b1;
              cursor_d = '0;
              done_d   = 1'b1;
            end
            OP_BUILD: begin
              let_d   = '0;
              head_d  = '0;
              tail_d  = '0;
              state_d = ST_R1;
            end
            OP_READ: begin
              tr_raddr = {NODE_W'(cmd_i.query_node), sym_in_idx};
              fl_raddr = NODE_W'(cmd_i.query_node);
              em_raddr = NODE_W'(cmd_i.query_node);
              if (node_ok_in) begin
                state_d = ST_RD;
              end else begin
                done_d = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_INS: begin
        // follow, allocate, or report a full table
        if (tr_rdata != '0) begin
          cursor_d = tr_rdata;
        end else if (room) begin
          tr_we    = 1'b1;
          tr_waddr = {cursor_q, sym_q_idx};
          tr_wdata = count_q[NODE_W-1:0];
          cursor_d = count_q[NODE_W-1:0];
          count_d  = count_q + 1'b1;
        end else begin
          res_d.status = 1'b1;
        end
        res_d.next_node = NODE_FW'(cursor_d);
        done_d          = 1'b1;
        state_d         = ST_IDLE;
      end
      ST_RD: begin
        res_d.next_node = sym_ok_q ? NODE_FW'(tr_rdata) : '0;
        res_d.fail_node = NODE_FW'(fl_rdata);
        res_d.is_end    = em_rdata;
        done_d          = node_ok_q;
        state_d         = ST_IDLE;
      end
      ST_R1: begin
        tr_raddr = {NODE_W'(0), let_q};
        state_d  = ST_R2;
      end
      ST_R2: begin
        // root children get failure link root and join the queue
        if (tr_rdata != '0 && tail_room) begin
          fl_we    = 1'b1;
          fl_waddr = tr_rdata;
          bq_we    = 1'b1;
          bq_waddr = tail_q[NODE_W-1:0];
          bq_wdata = tr_rdata;
          tail_d   = tail_q + 1'b1;
        end
        if (let_last) begin
          state_d = ST_BQ;
        end else begin
          let_d   = let_q + 1'b1;
          state_d = ST_R1;
        end
      end
      ST_BQ: begin
        if (head_q == tail_q) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          bq_raddr = head_q[NODE_W-1:0];
          head_d   = head_q + 1'b1;
          state_d  = ST_BU;
        end
      end
      ST_BU: begin
        u_d     = bq_rdata;
        let_d   = '0;
        state_d = ST_B1;
      end
      ST_B1: begin
        // failure link is fetched again for each letter of the row
        fl_raddr = u_q;
        tr_raddr = {u_q, let_q};
        state_d  = ST_B2;
      end
      ST_B2: begin
        nxt_d    = tr_rdata;
        tr_raddr = {fl_rdata, let_q};
        state_d  = ST_B3;
      end
      ST_B3: begin
        if (nxt_q != '0) begin
          fl_we    = 1'b1;
          fl_waddr = nxt_q;
          fl_wdata = tr_rdata;
          if (tail_room) begin
            bq_we    = 1'b1;
            bq_waddr = tail_q[NODE_W-1:0];
            bq_wdata = nxt_q;
            tail_d   = tail_q + 1'b1;
          end
        end else begin
          tr_we    = 1'b1;
          tr_waddr = {u_q, let_q};
          tr_wdata = tr_rdata;
        end
        if (let_last) begin
          state_d = ST_BQ;
        end else begin
          let_d   = let_q + 1'b1;
          state_d = ST_B1;
        end
      end
      default: state_d = ST_CLEAR;
    endcase

    res_d.node_count = COUNT_FW'(count_d);
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      cursor_q <= '0;
      count_q  <= CNT_W'(1);
      head_q   <= '0;
      tail_q   <= '0;
      let_q    <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      cursor_q <= cursor_d;
      count_q  <= count_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      let_q    <= let_d;
      done_q   <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    u_q   <= u_d;
    nxt_q <= nxt_d;
    res_q <= res_d;
  end

  assign busy   = state_q != ST_IDLE;
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

### rtl/mpab_ram.sv
// Simple dual-port synchronous RAM: one write and one registered read per cycle.
// No dependencies. Read of an address written in the same cycle returns old data.
module mpab_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 10
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
